// ===== sv/fpw_pkg.sv =====
`timescale 1ns / 1ps

package fpw_pkg;

  localparam int ChanBits  = 8;
  localparam int WordBits  = 32;
  localparam int CoordBits = 16;
  localparam int PitchBits = 18;
  localparam int CfgIdxBits = 3;

  typedef enum logic [1:0] {
    FMT_16 = 2'd0,
    FMT_24 = 2'd1,
    FMT_32 = 2'd2
  } pixel_format_t;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BASE   = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_PITCH  = 3'd3,
    REG_FORMAT = 3'd4,
    REG_RED    = 3'd5,
    REG_GREEN  = 3'd6,
    REG_BLUE   = 3'd7
  } cfg_reg_t;

  // bits 9:5 mask size, bits 4:0 bit position
  typedef struct packed {
    logic [4:0] size;
    logic [4:0] pos;
  } layout_t;

  localparam layout_t RedReset   = '{size: 5'd8, pos: 5'd16};
  localparam layout_t GreenReset = '{size: 5'd8, pos: 5'd8};
  localparam layout_t BlueReset  = '{size: 5'd8, pos: 5'd0};

  function automatic logic [WordBits-1:0] scale_channel(input logic [ChanBits-1:0] value,
                                                        input logic [4:0] size);
    logic [WordBits-1:0] wide;
    wide = {{(WordBits-ChanBits){1'b0}}, value};
    if (size == 5'd0) begin
      return '0;
    end else if (size >= 5'(ChanBits)) begin
      return wide << (size - 5'(ChanBits));
    end else begin
      return wide >> (5'(ChanBits) - size);
    end
  endfunction

  function automatic logic [2:0] bytes_of(input pixel_format_t fmt);
    logic [2:0] n;
    unique case (fmt)
      FMT_16:  n = 3'd2;
      FMT_24:  n = 3'd3;
      FMT_32:  n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/framebuffer_pixel_writer_unit.sv =====
`timescale 1ns / 1ps

// Pixel write unit: turns (x, y, r, g, b) requests into framebuffer byte writes.
// Requests: drive pixel_x, pixel_y, red, green, blue with start high; a request
// is taken on every edge where start is high and busy is low. busy stays low,
// so one request per clock is sustained.
// Results: done pulses for one cycle with write_address, write_data and
// byte_count. A request outside the frame, with frame width zero or a
// reserved pixel format, gives no done pulse.
// The pipeline has three register stages: multiply and scale, address sum
// and bit placement, then the output register.
// The receiver cannot stall; results are never held back.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index;
// cfg_ready is always high. Write only while no request is in flight.
// Reset (synchronous, active high) loads register defaults and empties the
// pipeline; requests are accepted in the first cycle after reset.
module framebuffer_pixel_writer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [fpw_pkg::CoordBits-1:0] pixel_x,
  input  logic [fpw_pkg::CoordBits-1:0] pixel_y,
  input  logic [fpw_pkg::ChanBits-1:0]  red,
  input  logic [fpw_pkg::ChanBits-1:0]  green,
  input  logic [fpw_pkg::ChanBits-1:0]  blue,
  output logic                          done,
  output logic [fpw_pkg::WordBits-1:0]  write_address,
  output logic [fpw_pkg::WordBits-1:0]  write_data,
  output logic [2:0]                    byte_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpw_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [fpw_pkg::WordBits-1:0]  cfg_data
);
  import fpw_pkg::*;

  localparam int XByteBits = CoordBits + 3;

  // configuration registers
  logic [WordBits-1:0]  base_address;
  logic [CoordBits-1:0] frame_width;
  logic [CoordBits-1:0] frame_height;
  logic [PitchBits-1:0] line_pitch;
  pixel_format_t        pixel_format;
  layout_t              red_layout;
  layout_t              green_layout;
  layout_t              blue_layout;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      frame_width  <= '0;
      frame_height <= '0;
      line_pitch   <= '0;
      pixel_format <= FMT_32;
      red_layout   <= RedReset;
      green_layout <= GreenReset;
      blue_layout  <= BlueReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE:   base_address <= cfg_data;
        REG_WIDTH:  frame_width  <= cfg_data[CoordBits-1:0];
        REG_HEIGHT: frame_height <= cfg_data[CoordBits-1:0];
        REG_PITCH:  line_pitch   <= cfg_data[PitchBits-1:0];
        REG_FORMAT: pixel_format <= pixel_format_t'(cfg_data[1:0]);
        REG_RED:    red_layout   <= layout_t'(cfg_data[9:0]);
        REG_GREEN:  green_layout <= layout_t'(cfg_data[9:0]);
        REG_BLUE:   blue_layout  <= layout_t'(cfg_data[9:0]);
        default: ;
      endcase
    end
  end

  // stage 1: clip test, address products
  logic                 in_frame;
  logic                 fmt_ok;
  logic [2:0]           bytes_in;
  logic                 s1_valid;
  logic [WordBits-1:0]  s1_row_offset;
  logic [XByteBits-1:0] s1_col_offset;
  logic [2:0]           s1_bytes;
  logic [CoordBits+PitchBits-1:0] row_product;

  assign in_frame    = (pixel_x < frame_width) && (pixel_y < frame_height);
  assign fmt_ok      = (pixel_format == FMT_16) || (pixel_format == FMT_24) ||
                       (pixel_format == FMT_32);
  assign bytes_in    = bytes_of(pixel_format);
  assign row_product = pixel_y * line_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy && in_frame && fmt_ok;
    end
  end

  always_ff @(posedge clk) begin
    s1_row_offset <= row_product[WordBits-1:0];
    s1_col_offset <= pixel_x * bytes_in;
    s1_bytes      <= bytes_in;
  end

  // stage 2: address sum
  logic                s2_valid;
  logic [WordBits-1:0] s2_address;
  logic [2:0]          s2_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_address <= base_address + s1_row_offset +
                  {{(WordBits-XByteBits){1'b0}}, s1_col_offset};
    s2_bytes   <= s1_bytes;
  end

  // channel packing runs alongside stages 1 and 2
  logic [WordBits-1:0] red_placed;
  logic [WordBits-1:0] green_placed;
  logic [WordBits-1:0] blue_placed;

  fpw_pack u_pack (
    .clk          (clk),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .red_layout   (red_layout),
    .green_layout (green_layout),
    .blue_layout  (blue_layout),
    .red_placed   (red_placed),
    .green_placed (green_placed),
    .blue_placed  (blue_placed)
  );

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    write_address <= s2_address;
    write_data    <= red_placed | green_placed | blue_placed;
    byte_count    <= s2_bytes;
  end

  a_done_from_request : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && in_frame && fmt_ok, 3))
    else $error("result without an in-frame request three cycles earlier");

  a_request_gives_done : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_frame && fmt_ok) |-> ##3 done)
    else $error("in-frame request produced no result");

  a_byte_count_legal : assert property (@(posedge clk) disable iff (rst)
    done |-> (byte_count == 3'd2 || byte_count == 3'd3 || byte_count == 3'd4))
    else $error("illegal byte count on result");

endmodule

// ===== sv/fpw_pack.sv =====
`timescale 1ns / 1ps

module fpw_pack (
  input  logic                        clk,
  input  logic [fpw_pkg::ChanBits-1:0] red,
  input  logic [fpw_pkg::ChanBits-1:0] green,
  input  logic [fpw_pkg::ChanBits-1:0] blue,
  input  fpw_pkg::layout_t            red_layout,
  input  fpw_pkg::layout_t            green_layout,
  input  fpw_pkg::layout_t            blue_layout,
  output logic [fpw_pkg::WordBits-1:0] red_placed,
  output logic [fpw_pkg::WordBits-1:0] green_placed,
  output logic [fpw_pkg::WordBits-1:0] blue_placed
);
  import fpw_pkg::*;

  logic [WordBits-1:0] red_scaled;
  logic [WordBits-1:0] green_scaled;
  logic [WordBits-1:0] blue_scaled;

  // first stage: scale to mask size, second: move to bit position
  always_ff @(posedge clk) begin
    red_scaled   <= scale_channel(red, red_layout.size);
    green_scaled <= scale_channel(green, green_layout.size);
    blue_scaled  <= scale_channel(blue, blue_layout.size);
  end

  always_ff @(posedge clk) begin
    red_placed   <= red_scaled << red_layout.pos;
    green_placed <= green_scaled << green_layout.pos;
    blue_placed  <= blue_scaled << blue_layout.pos;
  end

endmodule

// ===== tb/sv/pixel_write_checker.sv =====
`timescale 1ns / 1ps

module pixel_write_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [fpw_pkg::CoordBits-1:0]  pixel_x,
  input  logic [fpw_pkg::CoordBits-1:0]  pixel_y,
  input  logic [fpw_pkg::ChanBits-1:0]   red,
  input  logic [fpw_pkg::ChanBits-1:0]   green,
  input  logic [fpw_pkg::ChanBits-1:0]   blue,
  input  logic                           done,
  input  logic [fpw_pkg::WordBits-1:0]   write_address,
  input  logic [fpw_pkg::WordBits-1:0]   write_data,
  input  logic [2:0]                     byte_count,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fpw_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [fpw_pkg::WordBits-1:0]   cfg_data,
  output int                             fail_count,
  output int                             writes_pending,
  output int                             writes_checked
);
  import fpw_pkg::*;

  typedef struct packed {
    logic [WordBits-1:0] addr;
    logic [WordBits-1:0] data;
    logic [2:0]          count;
  } pixel_write_t;

  pixel_write_t awaiting [$];
  pixel_write_t want;

  // local copy of the register file
  logic [WordBits-1:0]  base;
  logic [CoordBits-1:0] width;
  logic [CoordBits-1:0] height;
  logic [PitchBits-1:0] pitch;
  logic [1:0]           format;
  layout_t              lay_r;
  layout_t              lay_g;
  layout_t              lay_b;

  task automatic report_mismatch(input string what, input logic [WordBits-1:0] seen,
                                 input logic [WordBits-1:0] wanted);
    $display("%0t: %s: got %h, want %h", $time, what, seen, wanted);
    fail_count++;
  endtask

  // scale to the mask size, then move to the bit position; upper bits fall off
  function automatic logic [WordBits-1:0] channel_bits(input logic [ChanBits-1:0] v,
                                                       input layout_t lay);
    logic [63:0] wide;
    int          shift;
    wide  = 64'(v);
    shift = int'(lay.size) - ChanBits;
    if (lay.size == 5'd0) begin
      wide = '0;
    end else if (shift >= 0) begin
      wide = wide << shift;
    end else begin
      wide = wide >> (-shift);
    end
    wide = wide << lay.pos;
    return wide[WordBits-1:0];
  endfunction

  function automatic bit predict_write(input logic [CoordBits-1:0] x, y,
                                       input logic [ChanBits-1:0] r, g, b,
                                       output pixel_write_t w);
    logic [2:0]  nbytes;
    logic [63:0] addr;
    w = '0;
    case (format)
      FMT_16:  nbytes = 3'd2;
      FMT_24:  nbytes = 3'd3;
      FMT_32:  nbytes = 3'd4;
      default: return 1'b0;
    endcase
    if (x >= width || y >= height) return 1'b0;
    addr = 64'(base) + 64'(y) * 64'(pitch) + 64'(x) * 64'(nbytes);
    w.addr  = addr[WordBits-1:0];
    w.data  = channel_bits(r, lay_r) | channel_bits(g, lay_g) | channel_bits(b, lay_b);
    w.count = nbytes;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      base   = '0;
      width  = '0;
      height = '0;
      pitch  = '0;
      format = FMT_32;
      lay_r  = RedReset;
      lay_g  = GreenReset;
      lay_b  = BlueReset;
      awaiting.delete();
      fail_count     = 0;
      writes_pending = 0;
      writes_checked = 0;
    end else begin
      if ($isunknown(done)) begin
        report_mismatch("done strobe unknown", 32'(done), '0);
      end else if (done) begin
        if (awaiting.size() == 0) begin
          report_mismatch("write with none expected, address", write_address, '0);
        end else begin
          want = awaiting.pop_front();
          if (write_address !== want.addr)
            report_mismatch("write_address", write_address, want.addr);
          if (write_data !== want.data)
            report_mismatch("write_data", write_data, want.data);
          if (byte_count !== want.count)
            report_mismatch("byte_count", 32'(byte_count), 32'(want.count));
          writes_checked++;
        end
      end
      if (start && !busy) begin
        if (predict_write(pixel_x, pixel_y, red, green, blue, want))
          awaiting.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE:   base   = cfg_data;
          REG_WIDTH:  width  = cfg_data[CoordBits-1:0];
          REG_HEIGHT: height = cfg_data[CoordBits-1:0];
          REG_PITCH:  pitch  = cfg_data[PitchBits-1:0];
          REG_FORMAT: format = cfg_data[1:0];
          REG_RED:    lay_r  = cfg_data[9:0];
          REG_GREEN:  lay_g  = cfg_data[9:0];
          REG_BLUE:   lay_b  = cfg_data[9:0];
          default:    ;
        endcase
      end
      writes_pending = awaiting.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fpw_pkg::*;

  localparam int PipeDepth     = 3;
  localparam int CycleLimit    = 100000;
  localparam int RandomPhases  = 9;
  localparam int ItemsPerPhase = 60;
  localparam logic [1:0] FmtReserved = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [CoordBits-1:0]  pixel_x;
  logic [CoordBits-1:0]  pixel_y;
  logic [ChanBits-1:0]   red;
  logic [ChanBits-1:0]   green;
  logic [ChanBits-1:0]   blue;
  logic                  done;
  logic [WordBits-1:0]   write_address;
  logic [WordBits-1:0]   write_data;
  logic [2:0]            byte_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [WordBits-1:0]   cfg_data;

  int fail_count;
  int writes_pending;
  int writes_checked;
  int cycles = 0;
  int sent = 0;
  int settings = 0;
  int cur_width = 0;
  int cur_height = 0;
  bit calm = 1'b0;
  logic [WordBits-1:0] reg_val [8];

  framebuffer_pixel_writer_unit dut (
    .clk, .rst, .start, .busy, .pixel_x, .pixel_y, .red, .green, .blue,
    .done, .write_address, .write_data, .byte_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pixel_write_checker checker_i (
    .clk, .rst, .start, .busy, .pixel_x, .pixel_y, .red, .green, .blue,
    .done, .write_address, .write_data, .byte_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .writes_pending, .writes_checked
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d writes outstanding", cycles, writes_pending);
      $display("framebuffer_pixel_writer_unit: mismatch");
      $finish;
    end
  end

  // writes the selected registers back to back, then drops valid once
  task automatic load_regs(input bit [7:0] which);
    for (int i = 0; i < 8; i++) begin
      if (which[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= CfgIdxBits'(i);
        cfg_data  <= reg_val[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
    if (which[REG_WIDTH])  cur_width  = int'(reg_val[REG_WIDTH][CoordBits-1:0]);
    if (which[REG_HEIGHT]) cur_height = int'(reg_val[REG_HEIGHT][CoordBits-1:0]);
    settings++;
  endtask

  task automatic send_pixel(input logic [CoordBits-1:0] x, y,
                            input logic [ChanBits-1:0] r, g, b);
    if (!calm) begin
      while ($urandom_range(0, 99) < 8) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    red     <= r;
    green   <= g;
    blue    <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // out-of-frame requests give no write, so allow the pipe to empty as well
  task automatic wait_idle();
    start <= 1'b0;
    while (writes_pending != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  function automatic logic [WordBits-1:0] pick_value(input int unsigned lo, hi);
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  // mostly inside the frame, some right at the border, some anywhere
  function automatic logic [CoordBits-1:0] pick_coord(input int limit);
    int roll;
    roll = $urandom_range(0, 19);
    if (limit == 0 || roll < 2) return CoordBits'($urandom_range(0, 65535));
    if (roll == 2) return CoordBits'(limit);
    if (roll == 3) return CoordBits'(limit - 1);
    return CoordBits'($urandom_range(0, limit - 1));
  endfunction

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    pixel_x   = '0;
    pixel_y   = '0;
    red       = '0;
    green     = '0;
    blue      = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero width, nothing may be written
    send_pixel(16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // geometry only, so the reset format and channel layouts are in use
    reg_val[REG_BASE]   = 32'h1000_0000;
    reg_val[REG_WIDTH]  = 32'd640;
    reg_val[REG_HEIGHT] = 32'd480;
    reg_val[REG_PITCH]  = 32'd2560;
    load_regs(8'b0000_1111);
    send_pixel(16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
    send_pixel(16'd639, 16'd479, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd640, 16'd0, 8'h12, 8'h34, 8'h56);
    send_pixel(16'd0, 16'd480, 8'h12, 8'h34, 8'h56);
    send_pixel(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd1, 16'd1, 8'hA5, 8'h5A, 8'h3C);
    wait_idle();

    // 565 layout, full-size frame, address wraps past the top
    reg_val[REG_BASE]   = 32'hFFFF_FF00;
    reg_val[REG_WIDTH]  = 32'd65535;
    reg_val[REG_HEIGHT] = 32'd65535;
    reg_val[REG_PITCH]  = 32'd262143;
    reg_val[REG_FORMAT] = 32'(FMT_16);
    reg_val[REG_RED]    = 32'(layout_t'{size: 5'd5, pos: 5'd11});
    reg_val[REG_GREEN]  = 32'(layout_t'{size: 5'd6, pos: 5'd5});
    reg_val[REG_BLUE]   = 32'(layout_t'{size: 5'd5, pos: 5'd0});
    load_regs(8'hFF);
    send_pixel(16'd65534, 16'd65534, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd0, 16'd0, 8'h80, 8'h40, 8'h20);
    send_pixel(16'd12345, 16'd54321, 8'h7F, 8'h01, 8'hFE);
    wait_idle();

    // 24 bpp, widest mask at the top bit, empty blue mask, zero pitch
    reg_val[REG_BASE]   = 32'hFFFF_FFFF;
    reg_val[REG_WIDTH]  = 32'd100;
    reg_val[REG_HEIGHT] = 32'd1;
    reg_val[REG_PITCH]  = 32'd0;
    reg_val[REG_FORMAT] = 32'(FMT_24);
    reg_val[REG_RED]    = 32'(layout_t'{size: 5'd31, pos: 5'd31});
    reg_val[REG_GREEN]  = 32'(layout_t'{size: 5'd12, pos: 5'd3});
    reg_val[REG_BLUE]   = 32'(layout_t'{size: 5'd0, pos: 5'd7});
    load_regs(8'hFF);
    send_pixel(16'd99, 16'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd0, 16'd0, 8'h01, 8'hC3, 8'h99);
    send_pixel(16'd50, 16'd1, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();

    // reserved format never writes
    reg_val[REG_FORMAT] = 32'(FmtReserved);
    load_regs(8'b0001_0000);
    send_pixel(16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd1, 16'd0, 8'h55, 8'hAA, 8'h0F);
    wait_idle();

    for (int p = 0; p < RandomPhases; p++) begin
      reg_val[REG_BASE]   = pick_value(0, 32'hFFFF_FFFF);
      reg_val[REG_WIDTH]  = pick_value(1, 65535);
      reg_val[REG_HEIGHT] = pick_value(1, 65535);
      reg_val[REG_PITCH]  = pick_value(0, 262143);
      reg_val[REG_FORMAT] = ($urandom_range(0, 9) == 0) ? 32'(FmtReserved)
                                                       : $urandom_range(FMT_16, FMT_32);
      reg_val[REG_RED]    = pick_value(0, 1023);
      reg_val[REG_GREEN]  = pick_value(0, 1023);
      reg_val[REG_BLUE]   = pick_value(0, 1023);
      load_regs(8'hFF);
      calm = (p == 3);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == 1 && n == ItemsPerPhase / 2) wait_idle();
        send_pixel(pick_coord(cur_width), pick_coord(cur_height),
                   ChanBits'($urandom_range(0, 255)), ChanBits'($urandom_range(0, 255)),
                   ChanBits'($urandom_range(0, 255)));
      end
      wait_idle();
    end

    $display("sent %0d pixel requests under %0d register loads", sent, settings);
    $display("compared %0d framebuffer writes, %0d field errors", writes_checked, fail_count);
    if (fail_count == 0) begin
      $display("framebuffer_pixel_writer_unit: match");
    end else begin
      $display("framebuffer_pixel_writer_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fpw_pkg.sv
sv/fpw_pack.sv
sv/framebuffer_pixel_writer_unit.sv
tb/sv/pixel_write_checker.sv
tb/sv/tb_top.sv
